[rtl/spq_pkg.sv]
// Package for the sorted priority queue: command, status and sequencer codes.
// Used by sorted_priority_queue and the testbench; no dependencies.
`timescale 1ns / 1ps

package spq_pkg;

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_POP      = 3'd2,
    CMD_CONTAINS = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CHECK,
    ST_INS_CMP,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_HEAD_RD,
    ST_HEAD_CAP,
    ST_FINISH
  } state_e;

endpackage

[rtl/spq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module spq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/sorted_priority_queue.sv]
// Sorted priority queue top level: sequencer, shared comparator, entry RAM.
// Depends on spq_pkg and spq_ram.
`timescale 1ns / 1ps

// Bounded min-priority queue holding up to CAPACITY signed 32-bit entries in
// ascending order in one RAM with a registered read port. One comparator
// (signed greater-than and equality against the command's key) is shared by
// every command under a small sequencer, and each stored entry it visits is
// first read, then compared and written. Insert walks from the tail down to its
// slot, moving each larger entry up by one. Remove, pop and contains walk from
// the head, contains stopping at its first match. Clear, unused codes and the
// empty or full cases go straight to the finish state. The input is stalled
// while a command runs; one finished result is held in the output register
// while the next command is accepted and worked on.
module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           command_i,
  input  logic signed [31:0]   item_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic signed [31:0]   result_value_o,
  output logic                 found_o,
  output logic signed [31:0]   head_value_o,
  output logic                 queue_empty_o,
  output logic [4:0]           entry_count_o
);
  import spq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  state_e          state_q, state_d;
  cmd_e            cmd_q, cmd_d;
  logic [31:0]     key_q, key_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic            hit_q, hit_d;
  logic            found_q, found_d;
  status_e         status_q, status_d;
  logic [31:0]     result_q, result_d;
  logic [31:0]     head_q, head_d;

  logic            ov_q;
  logic [1:0]      o_status_q;
  logic [31:0]     o_result_q;
  logic            o_found_q;
  logic [31:0]     o_head_q;
  logic            o_empty_q;
  logic [4:0]      o_count_q;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [31:0]     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [31:0]     ram_rdata;

  logic            in_acc;
  logic            out_free;
  logic            cmp_gt;
  logic            cmp_eq;
  logic [CW-1:0]   idx_dec;
  logic [CW-1:0]   idx_inc;
  logic            scan_take;
  logic [31:0]     count_ext;

  spq_ram #(
    .Width(32),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;

  // Shared compare unit against the latched key.
  assign cmp_gt  = $signed(ram_rdata) > $signed(key_q);
  assign cmp_eq  = (ram_rdata == key_q);
  assign idx_dec = idx_q - CW'(1);
  assign idx_inc = idx_q + CW'(1);
  // Scan picks this entry: pop takes the head, the others need a key match.
  assign scan_take = !hit_q && ((cmd_q == CMD_POP) || cmp_eq);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_e'(command_i))
            CMD_INSERT: begin
              state_d = (count_q == CapCount) ? ST_FINISH : ST_INS_CHECK;
            end
            CMD_REMOVE, CMD_POP, CMD_CONTAINS: begin
              state_d = (count_q == '0) ? ST_FINISH : ST_SCAN_RD;
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_INS_CHECK: state_d = (idx_q == '0) ? ST_HEAD_RD : ST_INS_CMP;
      ST_INS_CMP:   state_d = cmp_gt ? ST_INS_CHECK : ST_HEAD_RD;
      ST_SCAN_RD:   state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (cmd_q == CMD_CONTAINS && scan_take) begin
          state_d = ST_FINISH;
        end else if (idx_inc == count_q) begin
          state_d = (hit_q || scan_take) && cmd_q != CMD_CONTAINS ? ST_HEAD_RD : ST_FINISH;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_HEAD_RD:   state_d = ST_HEAD_CAP;
      ST_HEAD_CAP:  state_d = ST_FINISH;
      ST_FINISH:    state_d = out_free ? ST_IDLE : ST_FINISH;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    cmd_d     = cmd_q;
    key_d     = key_q;
    count_d   = count_q;
    idx_d     = idx_q;
    hit_d     = hit_q;
    found_d   = found_q;
    status_d  = status_q;
    result_d  = result_q;
    head_d    = head_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = key_q;
    ram_raddr = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d    = cmd_e'(command_i);
          key_d    = item_value_i;
          hit_d    = 1'b0;
          found_d  = 1'b0;
          status_d = STAT_OK;
          result_d = '0;
          case (cmd_e'(command_i))
            CMD_INSERT: begin
              if (count_q == CapCount) begin
                status_d = STAT_FULL;
              end
              idx_d = count_q;
            end
            CMD_REMOVE, CMD_POP, CMD_CONTAINS: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end
              idx_d = '0;
            end
            CMD_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      ST_INS_CHECK: begin
        ram_raddr = idx_dec[AW-1:0];
        if (idx_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          count_d   = count_q + CW'(1);
        end
      end
      ST_INS_CMP: begin
        // Move a larger entry up one slot, or drop the key into the gap.
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        if (cmp_gt) begin
          ram_wdata = ram_rdata;
          idx_d     = idx_dec;
        end else begin
          ram_wdata = key_q;
          count_d   = count_q + CW'(1);
        end
      end
      ST_SCAN_RD: ram_raddr = idx_q[AW-1:0];
      ST_SCAN_CMP: begin
        if (hit_q) begin
          // Close the gap behind the removed entry.
          ram_we    = 1'b1;
          ram_waddr = idx_dec[AW-1:0];
          ram_wdata = ram_rdata;
        end else if (scan_take) begin
          hit_d = 1'b1;
          if (cmd_q == CMD_CONTAINS) begin
            found_d = 1'b1;
          end else begin
            result_d = ram_rdata;
          end
        end
        idx_d = idx_inc;
        if (idx_inc == count_q && !(cmd_q == CMD_CONTAINS && scan_take)) begin
          if ((hit_q || scan_take) && cmd_q != CMD_CONTAINS) begin
            count_d = count_q - CW'(1);
          end else begin
            status_d = STAT_NOT_FOUND;
          end
        end
      end
      ST_HEAD_RD:  ram_raddr = '0;
      ST_HEAD_CAP: head_d = ram_rdata;
      default: ;
    endcase
  end

  assign count_ext = 32'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == ST_FINISH && out_free) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    idx_q    <= idx_d;
    hit_q    <= hit_d;
    found_q  <= found_d;
    status_q <= status_d;
    result_q <= result_d;
    head_q   <= head_d;
    // Load the output beat once the previous one has been taken.
    if (state_q == ST_FINISH && out_free) begin
      o_status_q <= status_q;
      o_result_q <= result_q;
      o_found_q  <= found_q;
      o_head_q   <= (count_q == '0) ? '0 : head_q;
      o_empty_q  <= (count_q == '0);
      o_count_q  <= count_ext[4:0];
    end
  end

  assign out_valid_o    = ov_q;
  assign status_o       = o_status_q;
  assign result_value_o = o_result_q;
  assign found_o        = o_found_q;
  assign head_value_o   = o_head_q;
  assign queue_empty_o  = o_empty_q;
  assign entry_count_o  = o_count_q;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for sorted_priority_queue: directed table, then random episodes.
// Depends on spq_pkg and the sorted_priority_queue RTL; predicts every result internally.
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int RANDOM_PER_PHASE = 382;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 64;

  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  // command codes the block treats as no-ops
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_value;
    logic               found;
    logic signed [31:0] head_value;
    logic               queue_empty;
    logic [4:0]         entry_count;
  } outcome_t;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] value;
    bit                 typed;
    outcome_t           want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         command_i = CMD_INSERT;
  logic signed [31:0] item_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] result_value_o;
  logic               found_o;
  logic signed [31:0] head_value_o;
  logic               queue_empty_o;
  logic [4:0]         entry_count_o;

  logic signed [31:0] shadow_entries[$];
  outcome_t           pending_outcomes[$];
  stim_row_t          directed_rows[$];

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int stalled_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int found_hits = 0;

  sorted_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .command_i,
    .item_value_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .result_value_o,
    .found_o,
    .head_value_o,
    .queue_empty_o,
    .entry_count_o
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Apply one command to the shadow list and return the result it should produce.
  function automatic outcome_t predict_outcome(logic [2:0] cmd, logic signed [31:0] val);
    outcome_t o;
    int       pos;
    o = '0;
    o.status = STAT_OK;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_entries.size() >= QUEUE_DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          // equal entries stay ahead of the new one
          pos = 0;
          while (pos < shadow_entries.size() && shadow_entries[pos] <= val) pos++;
          shadow_entries.insert(pos, val);
        end
      end
      CMD_REMOVE, CMD_CONTAINS: begin
        if (shadow_entries.size() == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          pos = 0;
          while (pos < shadow_entries.size() && shadow_entries[pos] != val) pos++;
          if (pos == shadow_entries.size()) begin
            o.status = STAT_NOT_FOUND;
          end else if (cmd == CMD_REMOVE) begin
            o.result_value = val;
            shadow_entries.delete(pos);
          end else begin
            o.found = 1'b1;
          end
        end
      end
      CMD_POP: begin
        if (shadow_entries.size() == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          o.result_value = shadow_entries.pop_front();
        end
      end
      CMD_CLEAR: begin
        shadow_entries.delete();
      end
      default: begin
      end
    endcase
    o.head_value  = (shadow_entries.size() != 0) ? shadow_entries[0] : '0;
    o.queue_empty = (shadow_entries.size() == 0);
    o.entry_count = 5'(shadow_entries.size());
    return o;
  endfunction

  function automatic outcome_t typed_outcome(logic [1:0] st, logic signed [31:0] res,
                                             logic fnd, logic signed [31:0] head, int count);
    outcome_t o;
    o.status       = st;
    o.result_value = res;
    o.found        = fnd;
    o.head_value   = head;
    o.queue_empty  = (count == 0);
    o.entry_count  = 5'(count);
    return o;
  endfunction

  task automatic add_row(logic [2:0] cmd, logic signed [31:0] val, bit typed, outcome_t want);
    stim_row_t r;
    r.cmd   = cmd;
    r.value = val;
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endtask

  // Present one beat, wait for the handshake, then record what it should produce.
  task automatic drive_beat(logic [2:0] cmd, logic signed [31:0] val,
                            bit typed = 1'b0, outcome_t want = '0);
    outcome_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i   <= 1'b0;
      command_i    <= 3'($urandom());
      item_value_i <= $urandom();
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    item_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_outcome(cmd, val);
    pending_outcomes.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return $urandom_range(16) - 8;
    if (roll < 60) begin
      case ($urandom_range(5))
        0: return MINV;
        1: return MINV + 1;
        2: return -1;
        3: return 0;
        4: return MAXV - 1;
        default: return MAXV;
      endcase
    end
    return $urandom();
  endfunction

  // Mostly a key that is held, so remove and contains get past the search.
  function automatic logic signed [31:0] pick_key();
    if (shadow_entries.size() != 0 && $urandom_range(99) < 70)
      return shadow_entries[$urandom_range(shadow_entries.size() - 1)];
    return pick_value();
  endfunction

  task automatic random_episode();
    int roll;
    int pick;
    roll = $urandom_range(99);
    if (roll < 20) begin
      // fill to capacity and push past it
      while (shadow_entries.size() < QUEUE_DEPTH) drive_beat(CMD_INSERT, pick_value());
      repeat ($urandom_range(2, 1)) drive_beat(CMD_INSERT, pick_value());
    end else if (roll < 35) begin
      // drain, then hit the empty cases
      while (shadow_entries.size() != 0) begin
        if ($urandom_range(99) < 60) drive_beat(CMD_POP, pick_value());
        else drive_beat(CMD_REMOVE, pick_key());
      end
      case ($urandom_range(2))
        0: drive_beat(CMD_POP, pick_value());
        1: drive_beat(CMD_REMOVE, pick_value());
        default: drive_beat(CMD_CONTAINS, pick_value());
      endcase
    end else if (roll < 38) begin
      drive_beat(CMD_CLEAR, pick_value());
    end else if (roll < 40) begin
      repeat ($urandom_range(4, 1)) drive_beat(3'($urandom()), $urandom());
    end else begin
      repeat ($urandom_range(12, 4)) begin
        pick = $urandom_range(99);
        if (pick < 35) drive_beat(CMD_INSERT, pick_value());
        else if (pick < 55) drive_beat(CMD_REMOVE, pick_key());
        else if (pick < 70) drive_beat(CMD_POP, pick_value());
        else if (pick < 92) drive_beat(CMD_CONTAINS, pick_key());
        else if (pick < 97) drive_beat(3'($urandom_range(CMD_SPARE_C, CMD_SPARE_A)), $urandom());
        else drive_beat(CMD_CLEAR, pick_value());
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result side: random stall, compare each accepted beat, watchdog.
  always @(posedge clk_i) begin : result_check
    outcome_t want;
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected result beat, status %0d value %h", $time, status_o,
                   result_value_o);
          errors++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("result_value", want.result_value, result_value_o);
          check_field("found", 32'(want.found), 32'(found_o));
          check_field("head_value", want.head_value, head_value_o);
          check_field("queue_empty", 32'(want.queue_empty), 32'(queue_empty_o));
          check_field("entry_count", 32'(want.entry_count), 32'(entry_count_o));
          results_checked++;
          status_seen[status_o]++;
          if (found_o) found_hits++;
        end
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        stalled_cycles <= stalled_cycles + 1;
      end
    end
  end

  initial begin
    // empty queue, extremes, not-found, duplicates, spare codes, clear
    add_row(CMD_POP,      0,    1'b1, typed_outcome(STAT_EMPTY, 0, 1'b0, 0, 0));
    add_row(CMD_REMOVE,   MAXV, 1'b1, typed_outcome(STAT_EMPTY, 0, 1'b0, 0, 0));
    add_row(CMD_CONTAINS, MINV, 1'b1, typed_outcome(STAT_EMPTY, 0, 1'b0, 0, 0));
    add_row(CMD_INSERT,   MAXV, 1'b1, typed_outcome(STAT_OK, 0, 1'b0, MAXV, 1));
    add_row(CMD_INSERT,   MINV, 1'b1, typed_outcome(STAT_OK, 0, 1'b0, MINV, 2));
    add_row(CMD_CONTAINS, 0,    1'b1, typed_outcome(STAT_NOT_FOUND, 0, 1'b0, MINV, 2));
    add_row(CMD_REMOVE,   0,    1'b1, typed_outcome(STAT_NOT_FOUND, 0, 1'b0, MINV, 2));
    add_row(CMD_CONTAINS, MAXV, 1'b0, '0);
    add_row(CMD_INSERT,   -1,   1'b0, '0);
    add_row(CMD_INSERT,   -1,   1'b0, '0);
    add_row(CMD_INSERT,   0,    1'b0, '0);
    add_row(CMD_INSERT,   MINV, 1'b0, '0);
    add_row(CMD_REMOVE,   -1,   1'b0, '0);
    add_row(CMD_POP,      MAXV, 1'b0, '0);
    add_row(CMD_POP,      0,    1'b0, '0);
    add_row(CMD_SPARE_A,  -1,   1'b0, '0);
    add_row(CMD_SPARE_B,  32'sh5A5A_5A5A, 1'b0, '0);
    add_row(CMD_SPARE_C,  MINV, 1'b0, '0);
    add_row(CMD_CONTAINS, -1,   1'b0, '0);
    add_row(CMD_REMOVE,   MAXV, 1'b0, '0);
    add_row(CMD_CLEAR,    MAXV, 1'b1, typed_outcome(STAT_OK, 0, 1'b0, 0, 0));
    add_row(CMD_CLEAR,    0,    1'b1, typed_outcome(STAT_OK, 0, 1'b0, 0, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      drive_beat(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].typed,
                 directed_rows[i].want);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int target = items_sent + RANDOM_PER_PHASE; items_sent < target; )
        random_episode();
    end
    in_valid_i <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d commands over four idle/stall mixes; checked %0d results.",
             items_sent, results_checked);
    $display("Status ok %0d, empty %0d, not found %0d, full %0d; contains hits %0d.",
             status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_NOT_FOUND],
             status_seen[STAT_FULL], found_hits);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
